// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define UVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication built on the clocked assertion.
`define UVS_IMPLY(lbl, ante, cons, msg) \
  `UVS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- hdl/uvs_pkg.sv -----
// Package: types, constants and reciprocal tables of the sphere tessellator.
package uvs_pkg;

  localparam int CFG_W  = 7;
  localparam int IDX_W  = 6;
  localparam int CIDX_W = 2;
  localparam int PH_W   = 16;

  localparam logic [CFG_W-1:0] MIN_LAT = 7'd2;
  localparam logic [CFG_W-1:0] MIN_LON = 7'd3;
  localparam logic [CFG_W-1:0] MAX_LAT = 7'd64;
  localparam logic [CFG_W-1:0] MAX_LON = 7'd64;
  localparam logic [CFG_W-1:0] RST_DIV = 7'd8;

  localparam logic [PH_W-1:0] HALF_TURN = 16'h8000;

  typedef enum logic [CIDX_W-1:0] {
    CFG_LAT_DIV = 2'd0,
    CFG_LON_DIV = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_BAD = 2'd0,
    KIND_TOP = 2'd1,
    KIND_BOT = 2'd2,
    KIND_MID = 2'd3
  } kind_e;

  // One classified band request
  typedef struct packed {
    kind_e           kind;
    logic [PH_W-1:0] t0;
    logic [PH_W-1:0] t1;
    logic [PH_W-1:0] p0;
    logic [PH_W-1:0] p1;
  } job_t;

  // Per-vertex sideband carried next to the trig pipeline
  typedef struct packed {
    logic last;
    logic bad;
  } vtx_t;

  // Trig pipeline: reduce, angle, square, four series levels, quadrant map
  localparam int SER_LVL  = 4;
  localparam int TRIG_LAT = 3 + 2 * SER_LVL + 1;

  localparam logic [29:0] PI4_Q30 = 30'd843314857;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  // Ceiling reciprocals for exact truncating division of values below 2^30
  localparam logic [5:0] SIN_SH [SER_LVL] = '{6'd33, 6'd35, 6'd36, 6'd37};
  localparam logic [5:0] COS_SH [SER_LVL] = '{6'd34, 6'd35, 6'd36, 6'd37};
  localparam logic [30:0] SIN_RC [SER_LVL] = '{
    31'(((64'd1 << 33) + 64'd5) / 64'd6),
    31'(((64'd1 << 35) + 64'd19) / 64'd20),
    31'(((64'd1 << 36) + 64'd41) / 64'd42),
    31'(((64'd1 << 37) + 64'd71) / 64'd72)
  };
  localparam logic [30:0] COS_RC [SER_LVL] = '{
    31'(((64'd1 << 34) + 64'd11) / 64'd12),
    31'(((64'd1 << 35) + 64'd29) / 64'd30),
    31'(((64'd1 << 36) + 64'd55) / 64'd56),
    31'(((64'd1 << 37) + 64'd89) / 64'd90)
  };

  // ceil(2^31 / d): phase = (N * RECIP[d]) >> 32 with N = 2*num*full + d
  localparam logic [31:0] R31M = 32'h7FFF_FFFF;
  localparam logic [31:0] RECIP [65] = '{
    32'd0,          32'(R31M / 1 + 1),  32'(R31M / 2 + 1),  32'(R31M / 3 + 1),
    32'(R31M / 4 + 1),  32'(R31M / 5 + 1),  32'(R31M / 6 + 1),  32'(R31M / 7 + 1),
    32'(R31M / 8 + 1),  32'(R31M / 9 + 1),  32'(R31M / 10 + 1), 32'(R31M / 11 + 1),
    32'(R31M / 12 + 1), 32'(R31M / 13 + 1), 32'(R31M / 14 + 1), 32'(R31M / 15 + 1),
    32'(R31M / 16 + 1), 32'(R31M / 17 + 1), 32'(R31M / 18 + 1), 32'(R31M / 19 + 1),
    32'(R31M / 20 + 1), 32'(R31M / 21 + 1), 32'(R31M / 22 + 1), 32'(R31M / 23 + 1),
    32'(R31M / 24 + 1), 32'(R31M / 25 + 1), 32'(R31M / 26 + 1), 32'(R31M / 27 + 1),
    32'(R31M / 28 + 1), 32'(R31M / 29 + 1), 32'(R31M / 30 + 1), 32'(R31M / 31 + 1),
    32'(R31M / 32 + 1), 32'(R31M / 33 + 1), 32'(R31M / 34 + 1), 32'(R31M / 35 + 1),
    32'(R31M / 36 + 1), 32'(R31M / 37 + 1), 32'(R31M / 38 + 1), 32'(R31M / 39 + 1),
    32'(R31M / 40 + 1), 32'(R31M / 41 + 1), 32'(R31M / 42 + 1), 32'(R31M / 43 + 1),
    32'(R31M / 44 + 1), 32'(R31M / 45 + 1), 32'(R31M / 46 + 1), 32'(R31M / 47 + 1),
    32'(R31M / 48 + 1), 32'(R31M / 49 + 1), 32'(R31M / 50 + 1), 32'(R31M / 51 + 1),
    32'(R31M / 52 + 1), 32'(R31M / 53 + 1), 32'(R31M / 54 + 1), 32'(R31M / 55 + 1),
    32'(R31M / 56 + 1), 32'(R31M / 57 + 1), 32'(R31M / 58 + 1), 32'(R31M / 59 + 1),
    32'(R31M / 60 + 1), 32'(R31M / 61 + 1), 32'(R31M / 62 + 1), 32'(R31M / 63 + 1),
    32'(R31M / 64 + 1)
  };

endpackage

// ----- hdl/uvs_if.sv -----
// Channel interfaces: band requests, vertex results and register writes.
interface uvs_in_if import uvs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] wedge_index;
  logic [IDX_W-1:0] band_index;
  modport source (output valid, wedge_index, band_index, input ready);
  modport sink (input valid, wedge_index, band_index, output ready);
endinterface

interface uvs_out_if import uvs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic               last_vertex;
  logic               bad_index;
  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  last_vertex, bad_index, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                last_vertex, bad_index, output ready);
endinterface

interface uvs_cfg_if import uvs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CFG_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/uvs_front.sv -----
// Front end: accept band requests, range-check them and compute their phases.
module uvs_front import uvs_pkg::*; (
  uvs_in_if.sink           in_chan,
  input  logic [CFG_W-1:0] lat_div_i,
  input  logic [CFG_W-1:0] lon_div_i,
  input  logic             full_i,
  output logic             push_o,
  output job_t             job_o
);

  logic [CFG_W-1:0] w_ext, b_ext;
  logic [23:0]      nt0, nt1;
  logic [22:0]      np0, np1;
  logic [55:0]      pt0, pt1;
  logic [54:0]      pp0, pp1;
  logic             bad;

  // Take a request whenever the queue has room
  assign in_chan.ready = !full_i;
  assign push_o        = in_chan.valid && !full_i;

  assign w_ext = {1'b0, in_chan.wedge_index};
  assign b_ext = {1'b0, in_chan.band_index};

  // Rounded phases through the reciprocal of the division count
  always_comb begin
    nt0 = {w_ext, 17'd0} + 24'(lon_div_i);
    nt1 = {w_ext + 7'd1, 17'd0} + 24'(lon_div_i);
    np0 = {b_ext, 16'd0} + 23'(lat_div_i);
    np1 = {b_ext + 7'd1, 16'd0} + 23'(lat_div_i);
    pt0 = 56'(nt0) * 56'(RECIP[lon_div_i]);
    pt1 = 56'(nt1) * 56'(RECIP[lon_div_i]);
    pp0 = 55'(np0) * 55'(RECIP[lat_div_i]);
    pp1 = 55'(np1) * 55'(RECIP[lat_div_i]);
  end

  // Classify the band
  always_comb begin
    bad      = (w_ext >= lon_div_i) || (b_ext >= lat_div_i);
    job_o.t0 = pt0[47:32];
    job_o.t1 = pt1[47:32];
    job_o.p0 = pp0[47:32];
    job_o.p1 = pp1[47:32];
    priority if (bad) begin
      job_o.kind = KIND_BAD;
    end else if (in_chan.band_index == '0) begin
      job_o.kind = KIND_TOP;
    end else if (b_ext == lat_div_i - 7'd1) begin
      job_o.kind = KIND_BOT;
    end else begin
      job_o.kind = KIND_MID;
    end
  end

endmodule

// ----- hdl/uvs_queue.sv -----
// Two-entry queue between the front end and the vertex engine.
module uvs_queue import uvs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- hdl/uvs_trig.sv -----
// Pipelined sine and cosine of a 16-bit phase, Q2.30 results.
module uvs_trig import uvs_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [PH_W-1:0]    phase_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  typedef struct packed {
    logic [1:0]         quad;
    logic               swp;
    logic [13:0]        rr;
    logic [30:0]        x;
    logic [30:0]        x2;
    logic [30:0]        m;
    logic [30:0]        n;
    logic signed [32:0] sa;
    logic signed [32:0] ca;
  } tstage_t;

  localparam int NST = TRIG_LAT - 1;

  tstage_t            st_q [NST];
  tstage_t            st_d [NST];
  logic signed [31:0] sin_q, cos_q;
  logic signed [31:0] sin_d, cos_d;

  function automatic logic [30:0] mulq(logic [30:0] a, logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b);
    p = p + (62'd1 << 29);
    return p[60:30];
  endfunction

  function automatic logic [30:0] cdiv(logic [30:0] v, logic [30:0] rc, logic [5:0] sh);
    logic [61:0] p;
    p = 62'(v) * 62'(rc);
    p = p >> sh;
    return p[30:0];
  endfunction

  always_comb begin
    logic [13:0] r;
    logic [43:0] xp;
    logic [30:0] sq;
    // Reduce to quadrant and octant
    st_d[0]      = '0;
    r            = phase_i[13:0];
    st_d[0].quad = phase_i[15:14];
    st_d[0].swp  = (r > 14'd8192);
    st_d[0].rr   = st_d[0].swp ? 14'(15'd16384 - 15'(r)) : r;
    // Octant angle in radians
    st_d[1]      = st_q[0];
    xp           = 44'(st_q[0].rr) * 44'(PI4_Q30) + 44'd4096;
    st_d[1].x    = 31'(xp >> 13);
    // Square and series start
    st_d[2]      = st_q[1];
    sq           = mulq(st_q[1].x, st_q[1].x);
    st_d[2].x2   = sq;
    st_d[2].m    = st_q[1].x;
    st_d[2].n    = sq >> 1;
    st_d[2].sa   = 33'(st_q[1].x);
    st_d[2].ca   = 33'(ONE_Q30) - 33'(sq >> 1);
    // Series levels: multiply by x^2, then divide by the term factor
    for (int l = 0; l < SER_LVL; l++) begin
      st_d[3 + 2 * l]   = st_q[2 + 2 * l];
      st_d[3 + 2 * l].m = mulq(st_q[2 + 2 * l].m, st_q[2 + 2 * l].x2);
      st_d[3 + 2 * l].n = mulq(st_q[2 + 2 * l].n, st_q[2 + 2 * l].x2);
      st_d[4 + 2 * l]   = st_q[3 + 2 * l];
      st_d[4 + 2 * l].m = cdiv(st_q[3 + 2 * l].m, SIN_RC[l], SIN_SH[l]);
      st_d[4 + 2 * l].n = cdiv(st_q[3 + 2 * l].n, COS_RC[l], COS_SH[l]);
      if (l % 2 == 0) begin
        st_d[4 + 2 * l].sa = st_q[3 + 2 * l].sa - 33'(st_d[4 + 2 * l].m);
        st_d[4 + 2 * l].ca = st_q[3 + 2 * l].ca + 33'(st_d[4 + 2 * l].n);
      end else begin
        st_d[4 + 2 * l].sa = st_q[3 + 2 * l].sa + 33'(st_d[4 + 2 * l].m);
        st_d[4 + 2 * l].ca = st_q[3 + 2 * l].ca - 33'(st_d[4 + 2 * l].n);
      end
    end
  end

  // Octant swap and quadrant signs
  always_comb begin
    logic signed [31:0] a, b;
    a = st_q[NST-1].swp ? 32'(st_q[NST-1].ca) : 32'(st_q[NST-1].sa);
    b = st_q[NST-1].swp ? 32'(st_q[NST-1].sa) : 32'(st_q[NST-1].ca);
    unique case (st_q[NST-1].quad)
      2'd0: begin sin_d = a;  cos_d = b;  end
      2'd1: begin sin_d = b;  cos_d = -a; end
      2'd2: begin sin_d = -a; cos_d = -b; end
      default: begin sin_d = -b; cos_d = a; end
    endcase
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NST; i++) begin
        st_q[i] <= st_d[i];
      end
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ----- hdl/uvs_back.sv -----
// Vertex engine: walk a band's vertices and turn angles into positions and normals.
module uvs_back import uvs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic pop_o,
  uvs_out_if.source out_chan
);

  logic               en, iss, last;
  logic [2:0]         k_q, k_d, nv_m1;
  logic [PH_W-1:0]    iss_phi, iss_th;
  vtx_t               iss_sb;
  logic               v_q [TRIG_LAT];
  vtx_t               sb_q [TRIG_LAT];
  logic signed [31:0] sp, cp, st, ct;
  logic               v0_q;
  vtx_t               sb0_q;
  logic signed [63:0] px_q, pz_q;
  logic signed [31:0] cp_q;
  logic               ov_q;

  function automatic logic [15:0] rnd_clamp(logic signed [63:0] v, logic [5:0] sh,
                                            logic [15:0] lim);
    logic [63:0] m, r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (sh - 6'd1))) >> sh;
    if (r > 64'(lim)) begin
      r = 64'(lim);
    end
    return v[63] ? 16'(~r[15:0] + 16'd1) : r[15:0];
  endfunction

  // Stall everything while a vertex waits at the output
  assign en = !out_chan.valid || out_chan.ready;

  // Pick the vertex angles of the current band
  always_comb begin
    iss_phi = '0;
    iss_th  = '0;
    nv_m1   = 3'd0;
    unique case (job_i.kind)
      KIND_BAD: begin
        nv_m1 = 3'd0;
      end
      KIND_TOP: begin
        nv_m1 = 3'd2;
        unique case (k_q)
          3'd0: begin iss_phi = '0; iss_th = '0; end
          3'd1: begin iss_phi = job_i.p1; iss_th = job_i.t0; end
          default: begin iss_phi = job_i.p1; iss_th = job_i.t1; end
        endcase
      end
      KIND_BOT: begin
        nv_m1 = 3'd2;
        unique case (k_q)
          3'd0: begin iss_phi = job_i.p0; iss_th = job_i.t0; end
          3'd1: begin iss_phi = HALF_TURN; iss_th = '0; end
          default: begin iss_phi = job_i.p0; iss_th = job_i.t1; end
        endcase
      end
      default: begin
        nv_m1 = 3'd5;
        unique case (k_q)
          3'd0: begin iss_phi = job_i.p0; iss_th = job_i.t0; end
          3'd1: begin iss_phi = job_i.p1; iss_th = job_i.t1; end
          3'd2: begin iss_phi = job_i.p0; iss_th = job_i.t1; end
          3'd3: begin iss_phi = job_i.p0; iss_th = job_i.t0; end
          3'd4: begin iss_phi = job_i.p1; iss_th = job_i.t0; end
          default: begin iss_phi = job_i.p1; iss_th = job_i.t1; end
        endcase
      end
    endcase
    last        = (k_q == nv_m1);
    iss         = en && job_valid_i;
    iss_sb.last = last;
    iss_sb.bad  = (job_i.kind == KIND_BAD);
    k_d         = k_q;
    if (iss) begin
      k_d = last ? 3'd0 : k_q + 3'd1;
    end
  end

  assign pop_o = iss && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= 3'd0;
    end else begin
      k_q <= k_d;
    end
  end

  uvs_trig u_phi (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (iss_phi),
    .sin_o   (sp),
    .cos_o   (cp)
  );

  uvs_trig u_th (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (iss_th),
    .sin_o   (st),
    .cos_o   (ct)
  );

  // Carry valid bits beside the trig pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TRIG_LAT; i++) begin
        v_q[i] <= 1'b0;
      end
      v0_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= job_valid_i;
      for (int i = 1; i < TRIG_LAT; i++) begin
        v_q[i] <= v_q[i-1];
      end
      v0_q <= v_q[TRIG_LAT-1];
      ov_q <= v0_q;
    end
  end

  // Sideband, products and the rounded output
  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= iss_sb;
      for (int i = 1; i < TRIG_LAT; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
      sb0_q <= sb_q[TRIG_LAT-1];
      px_q  <= sp * st;
      pz_q  <= sp * ct;
      cp_q  <= cp;
      out_chan.last_vertex <= sb0_q.last;
      out_chan.bad_index   <= sb0_q.bad;
      if (sb0_q.bad) begin
        out_chan.pos_x  <= '0;
        out_chan.pos_y  <= '0;
        out_chan.pos_z  <= '0;
        out_chan.norm_x <= '0;
        out_chan.norm_y <= '0;
        out_chan.norm_z <= '0;
      end else begin
        out_chan.pos_x  <= rnd_clamp(px_q, 6'd46, 16'd16384);
        out_chan.pos_y  <= rnd_clamp(64'(cp_q), 6'd16, 16'd16384);
        out_chan.pos_z  <= rnd_clamp(pz_q, 6'd46, 16'd16384);
        out_chan.norm_x <= rnd_clamp(px_q, 6'd45, 16'd32767);
        out_chan.norm_y <= rnd_clamp(64'(cp_q), 6'd15, 16'd32767);
        out_chan.norm_z <= rnd_clamp(pz_q, 6'd45, 16'd32767);
      end
    end
  end

  assign out_chan.valid = ov_q;

endmodule

// ----- hdl/uv_sphere_tessellator_core.sv -----
// Top level of the UV sphere tessellator: registers, front end, queue, vertex engine.
// Path to the output: queue, both trig pipelines, product and output registers.
// Throughput: one vertex per cycle unless the output stalls, set by the single vertex
// engine and output register; 6 vertices per middle band, 3 per pole band, 1 if bad.
// Reset: lat_div and lon_div return to 8, queue and pipeline empty out at once.
module uv_sphere_tessellator_core import uvs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  uvs_cfg_if.sink   cfg_chan,
  uvs_in_if.sink    in_chan,
  uvs_out_if.source out_chan
);

  logic [CFG_W-1:0] lat_q, lon_q, lat_d, lon_d;
  logic             push, full, pop, job_valid;
  job_t             job_in, job_out;

  assign cfg_chan.ready = 1'b1;

  // Clamp register writes into range
  always_comb begin
    lat_d = lat_q;
    lon_d = lon_q;
    if (cfg_chan.valid) begin
      if (cfg_chan.index == CFG_LAT_DIV) begin
        lat_d = (cfg_chan.data < MIN_LAT) ? MIN_LAT :
                (cfg_chan.data > MAX_LAT) ? MAX_LAT : cfg_chan.data;
      end
      if (cfg_chan.index == CFG_LON_DIV) begin
        lon_d = (cfg_chan.data < MIN_LON) ? MIN_LON :
                (cfg_chan.data > MAX_LON) ? MAX_LON : cfg_chan.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= RST_DIV;
      lon_q <= RST_DIV;
    end else begin
      lat_q <= lat_d;
      lon_q <= lon_d;
    end
  end

  uvs_front u_front (
    .in_chan   (in_chan),
    .lat_div_i (lat_q),
    .lon_div_i (lon_q),
    .full_i    (full),
    .push_o    (push),
    .job_o     (job_in)
  );

  uvs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  uvs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_chan    (out_chan)
  );

endmodule

// ----- hdl/uvs_checker.sv -----
// Port-level checker for the tessellator and its bind to the top level.
`include "assert_macros.svh"

module uvs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [15:0] pos_x_i,
  input logic [15:0] pos_y_i,
  input logic [15:0] norm_x_i,
  input logic [15:0] norm_y_i,
  input logic        last_i,
  input logic        bad_i
);

  // A bad request yields exactly one vertex
  `UVS_IMPLY(a_bad_last, valid_i && bad_i, last_i, "bad index result not last")

  // A bad request yields zero geometry; pos_x and norm_y are checked
  `UVS_IMPLY(a_bad_zero, valid_i && bad_i, (pos_x_i == 16'd0) && (norm_y_i == 16'd0), "bad index result not zero")

  // Normals saturate short of minus one
  `UVS_IMPLY(a_norm_sat, valid_i, (norm_x_i != 16'h8000) && (norm_y_i != 16'h8000), "normal out of range")

  // A stalled vertex holds
  `UVS_ASSERT(a_hold, valid_i && !ready_i |=> valid_i && $stable(pos_y_i), "stalled vertex changed")

endmodule

bind uv_sphere_tessellator_core uvs_checker u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .valid_i  (out_chan.valid),
  .ready_i  (out_chan.ready),
  .pos_x_i  (out_chan.pos_x),
  .pos_y_i  (out_chan.pos_y),
  .norm_x_i (out_chan.norm_x),
  .norm_y_i (out_chan.norm_y),
  .last_i   (out_chan.last_vertex),
  .bad_i    (out_chan.bad_index)
);

// ----- tb/uvs_tb_if.sv -----
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces come from the RTL interface file.
// This file holds a small helper package of testbench types.
package uvs_tb_pkg;
  typedef struct {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               last_vertex;
    logic               bad_index;
  } vertex_t;
endpackage

// ----- tb/uv_sphere_tessellator_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the UV sphere tessellator: directed and random band requests checked against a predictor.
module uv_sphere_tessellator_core_tb;
  import uvs_pkg::*;
  import uvs_tb_pkg::*;

  // Vertex predictor and queue of expected vertices
  class vertex_scoreboard;
    int unsigned lat_n = 8;
    int unsigned lon_n = 8;
    vertex_t pending[$];
    int errors = 0;
    int vertices_seen = 0;

    function void set_reg(cfg_idx_e idx, logic [6:0] val);
      int unsigned v;
      v = val;
      if (idx == CFG_LAT_DIV) begin
        if (v < 2) v = 2;
        if (v > 64) v = 64;
        lat_n = v;
      end else if (idx == CFG_LON_DIV) begin
        if (v < 3) v = 3;
        if (v > 64) v = 64;
        lon_n = v;
      end
    endfunction

    function longint unsigned mul30(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function void octant(int unsigned r, output longint unsigned s,
                         output longint unsigned c);
      longint unsigned x, x2, t3, t5, t7, t9, c2, c4, c6, c8, c10;
      x = (longint'(r) * 64'd843314857 + 4096) >> 13;
      x2 = mul30(x, x);
      t3 = mul30(x, x2) / 6;
      t5 = mul30(t3, x2) / 20;
      t7 = mul30(t5, x2) / 42;
      t9 = mul30(t7, x2) / 72;
      c2 = x2 / 2;
      c4 = mul30(c2, x2) / 12;
      c6 = mul30(c4, x2) / 30;
      c8 = mul30(c6, x2) / 56;
      c10 = mul30(c8, x2) / 90;
      s = x - t3 + t5 - t7 + t9;
      c = 64'd1073741824 - c2 + c4 - c6 + c8 - c10;
    endfunction

    function void sincos(int unsigned p, output longint sn, output longint cs);
      longint unsigned a, b;
      int unsigned q, r;
      p = p & 16'hFFFF;
      q = p >> 14;
      r = p & 16'h3FFF;
      if (r <= 8192) octant(r, a, b);
      else octant(16384 - r, b, a);
      case (q)
        0: begin sn = a; cs = b; end
        1: begin sn = b; cs = -longint'(a); end
        2: begin sn = -longint'(a); cs = -longint'(b); end
        default: begin sn = -longint'(b); cs = a; end
      endcase
    endfunction

    function logic signed [15:0] round_clamp(longint v, int sh, longint lim);
      longint unsigned m;
      longint r;
      m = (v < 0) ? -v : v;
      r = (m + (64'd1 << (sh - 1))) >> sh;
      if (v < 0) r = -r;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[15:0];
    endfunction

    function void push_vertex(int unsigned pphi, int unsigned pth, bit last);
      longint sp, cp, st, ct, px, pz;
      vertex_t v;
      sincos(pphi, sp, cp);
      sincos(pth, st, ct);
      px = sp * st;
      pz = sp * ct;
      v.pos_x = round_clamp(px, 46, 16384);
      v.pos_y = round_clamp(cp, 16, 16384);
      v.pos_z = round_clamp(pz, 46, 16384);
      v.norm_x = round_clamp(px, 45, 32767);
      v.norm_y = round_clamp(cp, 15, 32767);
      v.norm_z = round_clamp(pz, 45, 32767);
      v.last_vertex = last;
      v.bad_index = 0;
      pending.push_back(v);
    endfunction

    function int unsigned angle(int unsigned num, int unsigned full, int unsigned den);
      longint unsigned n;
      n = longint'(num) * full;
      return (2 * n + den) / (2 * longint'(den));
    endfunction

    // Note an accepted band request
    function void note_request(logic [5:0] w, logic [5:0] b);
      int unsigned t0, t1, p0, p1;
      vertex_t v;
      if (w >= lon_n || b >= lat_n) begin
        v = '{default: 0};
        v.last_vertex = 1;
        v.bad_index = 1;
        pending.push_back(v);
        return;
      end
      t0 = angle(w, 65536, lon_n) & 16'hFFFF;
      t1 = angle(w + 1, 65536, lon_n) & 16'hFFFF;
      p0 = angle(b, 32768, lat_n);
      p1 = angle(b + 1, 32768, lat_n);
      if (b == 0) begin
        push_vertex(0, 0, 0); push_vertex(p1, t0, 0); push_vertex(p1, t1, 1);
      end else if (b == lat_n - 1) begin
        push_vertex(p0, t0, 0); push_vertex(32768, 0, 0); push_vertex(p0, t1, 1);
      end else begin
        push_vertex(p0, t0, 0); push_vertex(p1, t1, 0); push_vertex(p0, t1, 0);
        push_vertex(p0, t0, 0); push_vertex(p1, t0, 0); push_vertex(p1, t1, 1);
      end
    endfunction

    // Compare an output vertex with the oldest expected one
    function void check_vertex(vertex_t got);
      vertex_t e;
      vertices_seen++;
      if (pending.size() == 0) begin
        $error("unexpected vertex transfer");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.pos_x !== e.pos_x) begin
        $error("pos_x exp %0d got %0d", e.pos_x, got.pos_x); errors++; end
      if (got.pos_y !== e.pos_y) begin
        $error("pos_y exp %0d got %0d", e.pos_y, got.pos_y); errors++; end
      if (got.pos_z !== e.pos_z) begin
        $error("pos_z exp %0d got %0d", e.pos_z, got.pos_z); errors++; end
      if (got.norm_x !== e.norm_x) begin
        $error("norm_x exp %0d got %0d", e.norm_x, got.norm_x); errors++; end
      if (got.norm_y !== e.norm_y) begin
        $error("norm_y exp %0d got %0d", e.norm_y, got.norm_y); errors++; end
      if (got.norm_z !== e.norm_z) begin
        $error("norm_z exp %0d got %0d", e.norm_z, got.norm_z); errors++; end
      if (got.last_vertex !== e.last_vertex) begin
        $error("last_vertex exp %0b got %0b", e.last_vertex, got.last_vertex); errors++; end
      if (got.bad_index !== e.bad_index) begin
        $error("bad_index exp %0b got %0b", e.bad_index, got.bad_index); errors++; end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  uvs_cfg_if cfg_chan ();
  uvs_in_if  in_chan ();
  uvs_out_if out_chan ();

  uv_sphere_tessellator_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_chan(cfg_chan), .in_chan(in_chan), .out_chan(out_chan)
  );

  vertex_scoreboard board;
  bit quiet_tail = 0;
  int requests_sent = 0;
  longint cycle_count = 0;

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  initial begin
    cfg_chan.valid = 0; cfg_chan.index = '0; cfg_chan.data = '0;
    in_chan.valid = 0; in_chan.wedge_index = '0; in_chan.band_index = '0;
    out_chan.ready = 0;
    board = new();
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sink side: random stall bursts, check each transfer
  always @(posedge clk_i) begin
    vertex_t got;
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      got.pos_x = out_chan.pos_x; got.pos_y = out_chan.pos_y;
      got.pos_z = out_chan.pos_z; got.norm_x = out_chan.norm_x;
      got.norm_y = out_chan.norm_y; got.norm_z = out_chan.norm_z;
      got.last_vertex = out_chan.last_vertex; got.bad_index = out_chan.bad_index;
      board.check_vertex(got);
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_chan.ready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_chan.ready <= 0;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_chan.ready <= 0;
    end else begin
      out_chan.ready <= 1;
    end
  end

  // Write one register while the block is idle; valid drops with the next request
  task automatic write_reg(cfg_idx_e idx, logic [6:0] val);
    cfg_chan.valid <= 1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    do @(posedge clk_i); while (!cfg_chan.ready);
    board.set_reg(idx, val);
  endtask

  // Send one band request, with an optional idle burst first
  task automatic send_band(logic [5:0] w, logic [5:0] b);
    int gap;
    cfg_chan.valid <= 0;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_chan.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_chan.valid <= 1;
    in_chan.wedge_index <= w;
    in_chan.band_index <= b;
    do @(posedge clk_i); while (!in_chan.ready);
    board.note_request(w, b);
    requests_sent++;
  endtask

  // Drop valid, wait until every expected vertex has come out, then settle
  task automatic drain();
    in_chan.valid <= 0;
    cfg_chan.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  // Random phase: mostly valid indexes, some out of range
  task automatic random_bands(int count);
    logic [5:0] w, b;
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) begin
        w = 6'($urandom); b = 6'($urandom);
      end else begin
        w = 6'($urandom_range(0, board.lon_n - 1));
        b = 6'($urandom_range(0, board.lat_n - 1));
      end
      send_band(w, b);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset settings, poles, middle, last wedge, bad indexes
    send_band(0, 0);
    send_band(7, 7);
    send_band(3, 4);
    send_band(7, 1);
    send_band(8, 0);
    send_band(0, 8);
    send_band(63, 63);
    drain();

    // Clamp below minimum, then the smallest sphere
    write_reg(CFG_LAT_DIV, 7'd0);
    write_reg(CFG_LON_DIV, 7'd1);
    send_band(0, 0); send_band(2, 1); send_band(3, 0); send_band(0, 2);
    drain();

    // Saturate above maximum, then the largest sphere
    write_reg(CFG_LAT_DIV, 7'd127);
    write_reg(CFG_LON_DIV, 7'd100);
    send_band(63, 63); send_band(0, 63); send_band(63, 0);
    send_band(21, 32); send_band(42, 5); send_band(1, 62);
    drain();

    // Random phases over several settings
    write_reg(CFG_LAT_DIV, 7'd64);
    write_reg(CFG_LON_DIV, 7'd64);
    random_bands(25);
    drain();
    write_reg(CFG_LAT_DIV, 7'($urandom_range(2, 64)));
    write_reg(CFG_LON_DIV, 7'($urandom_range(3, 64)));
    random_bands(30);
    drain();
    write_reg(CFG_LAT_DIV, 7'd2);
    write_reg(CFG_LON_DIV, 7'd3);
    random_bands(15);
    drain();
    write_reg(CFG_LAT_DIV, 7'($urandom_range(3, 40)));
    write_reg(CFG_LON_DIV, 7'($urandom_range(3, 40)));
    random_bands(25);

    // Tail with no idling on either side
    quiet_tail = 1;
    random_bands(20);
    drain();

    $display("Sent %0d band requests, checked %0d vertices over several divisions.",
             requests_sent, board.vertices_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
